// ===== hw/rtl/bdm_pkg.sv =====
package bdm_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int GAIN_BITS   = 10;
    localparam int EFF_BITS    = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [1:0] MODE_CHEAP = 2'd0;
    localparam logic [1:0] MODE_FULL  = 2'd1;
    localparam logic [1:0] MODE_LUMA  = 2'd2;
    localparam logic [1:0] MODE_RAW   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED_GAIN     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_GAIN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLUE_GAIN    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERALL_GAIN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_PHASE    = 3'd5;

    localparam logic [GAIN_BITS-1:0] RED_GAIN_RST     = 10'd300;
    localparam logic [GAIN_BITS-1:0] GREEN_GAIN_RST   = 10'd280;
    localparam logic [GAIN_BITS-1:0] BLUE_GAIN_RST    = 10'd360;
    localparam logic [GAIN_BITS-1:0] OVERALL_GAIN_RST = 10'd256;

    localparam logic [SAMPLE_BITS-1:0] PIX_MAX = 8'd255;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t    sample_above;
        sample_t    sample_center;
        sample_t    sample_below;
        logic       row_odd;
        logic       last_in_row;
    } in_item_t;

    typedef struct packed {
        sample_t    red;
        sample_t    green;
        sample_t    blue;
        logic       row_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [GAIN_BITS-1:0] red_gain;
        logic [GAIN_BITS-1:0] green_gain;
        logic [GAIN_BITS-1:0] blue_gain;
        logic [GAIN_BITS-1:0] overall_gain;
        logic                 col_phase;
    } cfg_t;

    typedef struct packed {
        sample_t    above;
        sample_t    center;
        sample_t    below;
    } column_t;

    // one pixel to be built: neighbor columns plus parities
    typedef struct packed {
        column_t    lf;
        column_t    md;
        column_t    rt;
        logic       rodd;
        logic       codd;
        logic       row_end;
    } job_t;

    typedef struct packed {
        logic       first;
        logic       second;
    } q_push_t;

    typedef struct packed {
        logic       room;
        logic       avail;
    } q_stat_t;

endpackage

// ===== hw/rtl/bdm_front.sv =====
module bdm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bdm_pkg::in_item_t in_data,
    input  logic              col_phase,
    input  bdm_pkg::q_stat_t  q_stat,
    output bdm_pkg::q_push_t  q_push,
    output bdm_pkg::job_t     job0,
    output bdm_pkg::job_t     job1
);
    import bdm_pkg::*;

    column_t left_reg, left_next;
    column_t mid_reg, mid_next;
    logic    pending_reg, pending_next;
    logic    codd_reg, codd_next;

    column_t col;
    logic    take;
    job_t    held_job;
    job_t    last_job;

    assign in_stall = !q_stat.room;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        col.above  = in_data.sample_above;
        col.center = in_data.sample_center;
        col.below  = in_data.sample_below;

        left_next    = left_reg;
        mid_next     = mid_reg;
        pending_next = pending_reg;
        codd_next    = codd_reg;

        held_job.lf      = left_reg;
        held_job.md      = mid_reg;
        held_job.rt      = col;
        held_job.rodd    = in_data.row_odd;
        held_job.codd    = codd_reg;
        held_job.row_end = 1'b0;

        if (take)
        begin
            if (!pending_reg)
            begin
                left_next    = col;
                mid_next     = col;
                codd_next    = col_phase;
                pending_next = 1'b1;
            end
            else
            begin
                left_next = mid_reg;
                mid_next  = col;
                codd_next = !codd_reg;
            end
            if (in_data.last_in_row)
            begin
                pending_next = 1'b0;
            end
        end

        // last column uses itself as right neighbor
        last_job.lf      = left_next;
        last_job.md      = mid_next;
        last_job.rt      = mid_next;
        last_job.rodd    = in_data.row_odd;
        last_job.codd    = codd_next;
        last_job.row_end = 1'b1;

        q_push.first  = take && (pending_reg || in_data.last_in_row);
        q_push.second = take && pending_reg && in_data.last_in_row;
        job0 = pending_reg ? held_job : last_job;
        job1 = last_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            codd_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            codd_reg    <= codd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        mid_reg  <= mid_next;
    end

endmodule

// ===== hw/rtl/bdm_queue.sv =====
module bdm_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bdm_pkg::q_push_t q_push,
    input  bdm_pkg::job_t    job0,
    input  bdm_pkg::job_t    job1,
    output bdm_pkg::q_stat_t q_stat,
    input  logic             pop,
    output bdm_pkg::job_t    head
);
    import bdm_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] ROOM_MAX = CNT_BITS'(DEPTH - 2);

    job_t                entries_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] wr_plus1;

    function automatic logic [PTR_BITS-1:0] step_ptr(input logic [PTR_BITS-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_BITS'(1);
    endfunction

    assign wr_plus1     = step_ptr(wr_reg);
    assign q_stat.room  = count_reg <= ROOM_MAX;
    assign q_stat.avail = count_reg != '0;
    assign head         = entries_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        if (q_push.second)
        begin
            wr_next = step_ptr(wr_plus1);
        end
        else if (q_push.first)
        begin
            wr_next = wr_plus1;
        end
        rd_next    = pop ? step_ptr(rd_reg) : rd_reg;
        count_next = count_reg + CNT_BITS'(q_push.first) + CNT_BITS'(q_push.second)
                     - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.first)
        begin
            entries_reg[wr_reg] <= job0;
        end
        if (q_push.second)
        begin
            entries_reg[wr_plus1] <= job1;
        end
    end

endmodule

// ===== hw/rtl/bdm_back.sv =====
module bdm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bdm_pkg::cfg_t      cfg,
    input  bdm_pkg::q_stat_t   q_stat,
    input  bdm_pkg::job_t      head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output bdm_pkg::out_item_t out_data
);
    import bdm_pkg::*;

    localparam int PROD_BITS = GAIN_BITS + GAIN_BITS;
    localparam int PIX_BITS  = SAMPLE_BITS + EFF_BITS;

    logic [EFF_BITS-1:0] eff_r_reg, eff_g_reg, eff_b_reg;
    logic [PROD_BITS-1:0] prod_r, prod_g, prod_b;

    logic    s1_valid_reg, s1_valid_next;
    sample_t s1_r_reg, s1_g_reg, s1_b_reg;
    logic    s1_gain_reg;
    logic    s1_end_reg;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;

    logic    out_ready;
    logic    s1_ready;
    sample_t r_raw, g_raw, b_raw;

    logic                   color_site;
    logic [SAMPLE_BITS:0]   pair_a, pair_b;
    logic [SAMPLE_BITS+1:0] quad_a, quad_b;

    // effective gains only change with config, so they sit in registers
    assign prod_r = cfg.red_gain * cfg.overall_gain;
    assign prod_g = cfg.green_gain * cfg.overall_gain;
    assign prod_b = cfg.blue_gain * cfg.overall_gain;

    always_ff @(posedge clk)
    begin
        eff_r_reg <= prod_r[PROD_BITS-1:8];
        eff_g_reg <= prod_g[PROD_BITS-1:8];
        eff_b_reg <= prod_b[PROD_BITS-1:8];
    end

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = q_stat.avail && s1_ready;

    always_comb
    begin
        color_site = head.rodd == head.codd;
        r_raw = '0;
        g_raw = '0;
        b_raw = '0;
        pair_a = '0;
        pair_b = '0;
        quad_a = '0;
        quad_b = '0;
        case (cfg.mode)
            MODE_CHEAP:
            begin
                if (color_site)
                begin
                    pair_a = {1'b0, head.lf.below} + {1'b0, head.rt.below};
                    pair_b = {1'b0, head.rt.center} + {1'b0, head.md.above};
                    g_raw  = pair_b[SAMPLE_BITS:1];
                    if (!head.rodd)
                    begin
                        b_raw = head.md.center;
                        r_raw = pair_a[SAMPLE_BITS:1];
                    end
                    else
                    begin
                        r_raw = head.md.center;
                        b_raw = pair_a[SAMPLE_BITS:1];
                    end
                end
                else
                begin
                    g_raw = head.md.center;
                    if (!head.rodd)
                    begin
                        b_raw = head.rt.center;
                        r_raw = head.md.above;
                    end
                    else
                    begin
                        r_raw = head.rt.center;
                        b_raw = head.md.above;
                    end
                end
            end
            MODE_FULL:
            begin
                if (color_site)
                begin
                    quad_a = {2'b0, head.lf.below} + {2'b0, head.rt.below}
                           + {2'b0, head.lf.above} + {2'b0, head.rt.above};
                    quad_b = {2'b0, head.rt.center} + {2'b0, head.md.above}
                           + {2'b0, head.lf.center} + {2'b0, head.md.below};
                    g_raw  = quad_b[SAMPLE_BITS+1:2];
                    if (!head.rodd)
                    begin
                        b_raw = head.md.center;
                        r_raw = quad_a[SAMPLE_BITS+1:2];
                    end
                    else
                    begin
                        r_raw = head.md.center;
                        b_raw = quad_a[SAMPLE_BITS+1:2];
                    end
                end
                else
                begin
                    pair_a = {1'b0, head.rt.center} + {1'b0, head.lf.center};
                    pair_b = {1'b0, head.md.above} + {1'b0, head.md.below};
                    g_raw  = head.md.center;
                    if (!head.rodd)
                    begin
                        b_raw = pair_a[SAMPLE_BITS:1];
                        r_raw = pair_b[SAMPLE_BITS:1];
                    end
                    else
                    begin
                        r_raw = pair_a[SAMPLE_BITS:1];
                        b_raw = pair_b[SAMPLE_BITS:1];
                    end
                end
            end
            MODE_LUMA:
            begin
                quad_b = {2'b0, head.rt.center} + {2'b0, head.md.above}
                       + {2'b0, head.lf.center} + {2'b0, head.md.below};
                g_raw  = color_site ? quad_b[SAMPLE_BITS+1:2] : head.md.center;
                r_raw  = g_raw;
                b_raw  = g_raw;
            end
            default:
            begin
                if (!color_site)
                begin
                    g_raw = head.md.center;
                end
                else if (!head.rodd)
                begin
                    b_raw = head.md.center;
                end
                else
                begin
                    r_raw = head.md.center;
                end
            end
        endcase
    end

    function automatic sample_t gain_sat(input sample_t v, input logic [EFF_BITS-1:0] eff);
        logic [PIX_BITS-1:0] p;
        logic [EFF_BITS-1:0] x;
        p = v * eff;
        x = p[PIX_BITS-1:8];
        return (x > EFF_BITS'(PIX_MAX)) ? PIX_MAX : x[SAMPLE_BITS-1:0];
    endfunction

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = pop;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_r_reg    <= r_raw;
            s1_g_reg    <= g_raw;
            s1_b_reg    <= b_raw;
            s1_gain_reg <= (cfg.mode == MODE_CHEAP) || (cfg.mode == MODE_FULL);
            s1_end_reg  <= head.row_end;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_reg.red     <= s1_gain_reg ? gain_sat(s1_r_reg, eff_r_reg) : s1_r_reg;
            out_reg.green   <= s1_gain_reg ? gain_sat(s1_g_reg, eff_g_reg) : s1_g_reg;
            out_reg.blue    <= s1_gain_reg ? gain_sat(s1_b_reg, eff_b_reg) : s1_b_reg;
            out_reg.row_end <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/bayer_demosaic_with_gains.sv =====
// channel   direction  transfer when            payload
// in        input      in_valid && !in_stall    in_data   (one bayer column)
// out       output     out_valid && !out_stall  out_data  (one rgb pixel)
// cfg       input      cfg_we                   cfg_index, cfg_data
//
// one column accepted per cycle while in_stall is low; a column marked last in row queues two pixels,
// and the single-pixel output port then sets the rate for that item
// a pixel leaves after its column has passed queue write, pattern stage and gain stage
// in_stall rises when the job queue has room for fewer than two pixels
// reset clears the held-column flag, the queue and the pipeline; config regs load defaults
module bayer_demosaic_with_gains #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  bdm_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output bdm_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [bdm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bdm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import bdm_pkg::*;

    cfg_t    cfg_reg;
    q_stat_t q_stat;
    q_push_t q_push;
    job_t    job0;
    job_t    job1;
    job_t    head;
    logic    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_CHEAP;
            cfg_reg.red_gain     <= RED_GAIN_RST;
            cfg_reg.green_gain   <= GREEN_GAIN_RST;
            cfg_reg.blue_gain    <= BLUE_GAIN_RST;
            cfg_reg.overall_gain <= OVERALL_GAIN_RST;
            cfg_reg.col_phase    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:         cfg_reg.mode         <= cfg_data[1:0];
                REG_RED_GAIN:     cfg_reg.red_gain     <= cfg_data[GAIN_BITS-1:0];
                REG_GREEN_GAIN:   cfg_reg.green_gain   <= cfg_data[GAIN_BITS-1:0];
                REG_BLUE_GAIN:    cfg_reg.blue_gain    <= cfg_data[GAIN_BITS-1:0];
                REG_OVERALL_GAIN: cfg_reg.overall_gain <= cfg_data[GAIN_BITS-1:0];
                REG_COL_PHASE:    cfg_reg.col_phase    <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bdm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .col_phase (cfg_reg.col_phase),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .job0      (job0),
        .job1      (job1)
    );

    bdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .job0   (job0),
        .job1   (job1),
        .q_stat (q_stat),
        .pop    (pop),
        .head   (head)
    );

    bdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
